// ===== src/sfp_pkg.sv =====
package sfp_pkg;

    localparam int RX_W      = 8;
    localparam int HANDLE_W  = 8;
    localparam int LEN_W     = 6;
    localparam int IDX_W     = 5;
    localparam int SUM_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [RX_W-1:0] SYNC_BYTE = 8'hAA;

    localparam logic [CFG_IDX_W-1:0] CFG_HANDLE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 1'd1;

    localparam logic [HANDLE_W-1:0] HANDLE_LIMIT_RST = 8'd16;
    localparam logic [LEN_W-1:0]    MAX_LENGTH_RST   = 6'd20;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_HANDLE,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PAYLOAD,
        ST_SUM_LO,
        ST_SUM_HI,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_handle;
        logic take_len_lo;
        logic take_len_hi;
        logic take_payload;
        logic take_sum_lo;
        logic clr_idx;
        logic inc_idx;
        logic load_out;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic sync_hit;
        logic handle_ok;
        logic len_over;
        logic len_zero;
        logic payload_done;
        logic sum_match;
        logic last_item;
        logic out_free;
    } status_t;

endpackage

// ===== src/sfp_rx_if.sv =====
interface sfp_rx_if;
    logic                        valid;
    logic                        ready;
    logic [sfp_pkg::RX_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/sfp_res_if.sv =====
interface sfp_res_if;
    logic                         valid;
    logic                         ready;
    logic [sfp_pkg::HANDLE_W-1:0] frame_handle;
    logic [sfp_pkg::RX_W-1:0]     data_byte;
    logic [sfp_pkg::IDX_W-1:0]    byte_index;
    logic [sfp_pkg::LEN_W-1:0]    frame_length;
    logic                         empty_frame;
    logic                         last;

    modport source (output valid, output frame_handle, output data_byte,
                    output byte_index, output frame_length, output empty_frame,
                    output last, input ready);
    modport sink   (input valid, input frame_handle, input data_byte,
                    input byte_index, input frame_length, input empty_frame,
                    input last, output ready);
endinterface

// ===== src/sfp_ram.sv =====
module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/sfp_ctrl.sv =====
module sfp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sfp_pkg::status_t  status,
    output sfp_pkg::cmd_t     cmd
);

    sfp_pkg::state_t state_reg;
    sfp_pkg::state_t state_next;
    logic            in_fire;

    assign in_ready = (state_reg != sfp_pkg::ST_EMIT_RD) && (state_reg != sfp_pkg::ST_EMIT_LD);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfp_pkg::ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfp_pkg::ST_HUNT:
            begin
                if (in_fire && status.sync_hit)
                begin
                    state_next = sfp_pkg::ST_HANDLE;
                end
            end
            sfp_pkg::ST_HANDLE:
            begin
                if (in_fire)
                begin
                    state_next = status.handle_ok ? sfp_pkg::ST_LEN_LO : sfp_pkg::ST_HUNT;
                end
            end
            sfp_pkg::ST_LEN_LO:
            begin
                if (in_fire)
                begin
                    state_next = sfp_pkg::ST_LEN_HI;
                end
            end
            sfp_pkg::ST_LEN_HI:
            begin
                if (in_fire)
                begin
                    priority if (status.len_over)
                        state_next = sfp_pkg::ST_HUNT;
                    else if (status.len_zero)
                        state_next = sfp_pkg::ST_SUM_LO;
                    else
                        state_next = sfp_pkg::ST_PAYLOAD;
                end
            end
            sfp_pkg::ST_PAYLOAD:
            begin
                if (in_fire && status.payload_done)
                begin
                    state_next = sfp_pkg::ST_SUM_LO;
                end
            end
            sfp_pkg::ST_SUM_LO:
            begin
                if (in_fire)
                begin
                    state_next = sfp_pkg::ST_SUM_HI;
                end
            end
            sfp_pkg::ST_SUM_HI:
            begin
                if (in_fire)
                begin
                    state_next = status.sum_match ? sfp_pkg::ST_EMIT_RD : sfp_pkg::ST_HUNT;
                end
            end
            sfp_pkg::ST_EMIT_RD:
            begin
                state_next = sfp_pkg::ST_EMIT_LD;
            end
            sfp_pkg::ST_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_item ? sfp_pkg::ST_HUNT : sfp_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = sfp_pkg::ST_HUNT;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            sfp_pkg::ST_HUNT:    ;
            sfp_pkg::ST_HANDLE:  cmd.take_handle  = in_fire;
            sfp_pkg::ST_LEN_LO:  cmd.take_len_lo  = in_fire;
            sfp_pkg::ST_LEN_HI:  cmd.take_len_hi  = in_fire;
            sfp_pkg::ST_PAYLOAD: cmd.take_payload = in_fire;
            sfp_pkg::ST_SUM_LO:  cmd.take_sum_lo  = in_fire;
            sfp_pkg::ST_SUM_HI:  cmd.clr_idx      = in_fire;
            sfp_pkg::ST_EMIT_RD: ;
            sfp_pkg::ST_EMIT_LD:
            begin
                cmd.load_out = status.out_free;
                cmd.inc_idx  = status.out_free && !status.last_item;
            end
            default: ;
        endcase
    end

endmodule

// ===== src/sfp_dp.sv =====
module sfp_dp #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfp_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic [sfp_pkg::RX_W-1:0]          rx_byte,
    input  logic                              out_ready,
    input  sfp_pkg::cmd_t                     cmd,
    output sfp_pkg::status_t                  status,
    output logic                              out_valid,
    output logic [sfp_pkg::HANDLE_W-1:0]      frame_handle,
    output logic [sfp_pkg::RX_W-1:0]          data_byte,
    output logic [sfp_pkg::IDX_W-1:0]         byte_index,
    output logic [sfp_pkg::LEN_W-1:0]         frame_length,
    output logic                              empty_frame,
    output logic                              last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LW = sfp_pkg::LEN_W;

    logic [sfp_pkg::HANDLE_W-1:0] handle_limit_reg;
    logic [LW-1:0]                max_length_reg;
    logic [sfp_pkg::HANDLE_W-1:0] handle_reg;
    logic [sfp_pkg::RX_W-1:0]     len_lo_reg;
    logic [LW-1:0]                len_reg;
    logic [LW-1:0]                count_reg;
    logic [LW-1:0]                idx_reg;
    logic [sfp_pkg::SUM_W-1:0]    sum_reg;
    logic [sfp_pkg::RX_W-1:0]     sum_lo_reg;

    logic                         out_valid_reg;
    logic [sfp_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [sfp_pkg::RX_W-1:0]     out_data_reg;
    logic [sfp_pkg::IDX_W-1:0]    out_idx_reg;
    logic [sfp_pkg::LEN_W-1:0]    out_len_reg;
    logic                         out_empty_reg;
    logic                         out_last_reg;

    logic [2*sfp_pkg::RX_W-1:0]   len_full;
    logic [LW-1:0]                len_limit;
    logic [LW-1:0]                count_inc;
    logic [LW-1:0]                idx_inc;
    logic                         len_empty;
    logic [AW+LW-1:0]             waddr_ext;
    logic [AW+LW-1:0]             raddr_ext;
    logic [sfp_pkg::RX_W-1:0]     ram_rdata;

    // Effective length limit: the register, clipped to the store depth.
    always_comb
    begin
        if (32'(max_length_reg) > MAX_PAYLOAD)
            len_limit = LW'(MAX_PAYLOAD);
        else
            len_limit = max_length_reg;
    end

    assign len_full  = {rx_byte, len_lo_reg};
    assign count_inc = count_reg + LW'(1);
    assign idx_inc   = idx_reg + LW'(1);
    assign len_empty = (len_reg == '0);
    assign waddr_ext = {{AW{1'b0}}, count_reg};
    assign raddr_ext = {{AW{1'b0}}, idx_reg};

    assign status.sync_hit     = (rx_byte == sfp_pkg::SYNC_BYTE);
    assign status.handle_ok    = (rx_byte < handle_limit_reg);
    assign status.len_over     = (len_full > {{(2*sfp_pkg::RX_W-LW){1'b0}}, len_limit});
    assign status.len_zero     = (len_full == '0);
    assign status.payload_done = (count_inc >= len_reg);
    assign status.sum_match    = ({rx_byte, sum_lo_reg} == sum_reg);
    assign status.last_item    = len_empty || (idx_inc == len_reg);
    assign status.out_free     = !out_valid_reg || out_ready;

    sfp_ram #(
        .WIDTH (sfp_pkg::RX_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (cmd.take_payload),
        .waddr (waddr_ext[AW-1:0]),
        .wdata (rx_byte),
        .raddr (raddr_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handle_limit_reg <= sfp_pkg::HANDLE_LIMIT_RST;
            max_length_reg   <= sfp_pkg::MAX_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfp_pkg::CFG_HANDLE_LIMIT: handle_limit_reg <= cfg_data;
                sfp_pkg::CFG_MAX_LENGTH:   max_length_reg   <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handle_reg <= '0;
            len_lo_reg <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            sum_reg    <= '0;
            sum_lo_reg <= '0;
        end
        else
        begin
            if (cmd.take_handle)
                handle_reg <= rx_byte;
            if (cmd.take_len_lo)
                len_lo_reg <= rx_byte;
            if (cmd.take_len_hi)
            begin
                // Only the low bits matter once the limit check has passed.
                len_reg   <= len_full[LW-1:0];
                count_reg <= '0;
                sum_reg   <= '0;
            end
            if (cmd.take_payload)
            begin
                count_reg <= count_inc;
                sum_reg   <= sum_reg + {{(sfp_pkg::SUM_W-sfp_pkg::RX_W){1'b0}}, rx_byte};
            end
            if (cmd.take_sum_lo)
                sum_lo_reg <= rx_byte;
            if (cmd.clr_idx)
                idx_reg <= '0;
            else if (cmd.inc_idx)
                idx_reg <= idx_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_handle_reg <= handle_reg;
            out_data_reg   <= len_empty ? '0 : ram_rdata;
            out_idx_reg    <= idx_reg[sfp_pkg::IDX_W-1:0];
            out_len_reg    <= len_reg;
            out_empty_reg  <= len_empty;
            out_last_reg   <= status.last_item;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_handle = out_handle_reg;
    assign data_byte    = out_data_reg;
    assign byte_index   = out_idx_reg;
    assign frame_length = out_len_reg;
    assign empty_frame  = out_empty_reg;
    assign last         = out_last_reg;

endmodule

// ===== src/sync_frame_parser.sv =====
// Channel     Direction  Payload
// byte_in     sink       rx_byte[7:0]
// result_out  source     frame_handle[7:0], data_byte[7:0], byte_index[4:0],
//                        frame_length[5:0], empty_frame, last
// cfg         write      cfg_we, cfg_index[0:0], cfg_data[7:0]
//
// While a frame is being parsed, one received byte is taken per cycle. After a
// frame whose checksum matches, the stored payload is read out of the payload
// memory one result at a time (memory read, then load of the output register),
// and intake stalls until the readout is done; an empty frame still gives one
// result. rst_n clears the parser to sync hunt and the registers to their
// defaults; the payload memory is not cleared. Back pressure on result_out only
// holds the readout; the last result of a frame may wait while new bytes flow.

module sync_frame_parser #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfp_pkg::CFG_DAT_W-1:0] cfg_data,
    sfp_rx_if.sink                        byte_in,
    sfp_res_if.source                     result_out
);

    // Command and status buses between the controller and the datapath.
    sfp_pkg::cmd_t    cmd;
    sfp_pkg::status_t status;

    // The controller sequences the frame fields and the payload readout.
    sfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_in.valid),
        .in_ready (byte_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the registers, the checksum, the payload memory and
    // the output register that decouples readout from the result consumer.
    sfp_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (byte_in.rx_byte),
        .out_ready    (result_out.ready),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (result_out.valid),
        .frame_handle (result_out.frame_handle),
        .data_byte    (result_out.data_byte),
        .byte_index   (result_out.byte_index),
        .frame_length (result_out.frame_length),
        .empty_frame  (result_out.empty_frame),
        .last         (result_out.last)
    );

endmodule
